FILE: design/wpf_pkg.sv
// Shared constants and codes for the waypoint follower.
// No dependencies; used by waypoint_follower_step_top.
`default_nettype none
package wpf_pkg;

	localparam int MAX_WAYPOINTS = 64;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_APPEND   = 3'd1,
		CMD_SET_POS  = 3'd2,
		CMD_STOP     = 3'd3,
		CMD_NOTFOUND = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_MOVING   = 2'd1,
		ST_ARRIVED  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		REG_MAX_SPEED      = 1'b0,
		REG_ARRIVAL_RADIUS = 1'b1
	} reg_index_t;

endpackage
`default_nettype wire

FILE: design/waypoint_follower_step_top.sv
// Waypoint follower top level: waypoint memory, sequencer and shared multiplier.
// Depends on wpf_pkg.
`default_nettype none
// Moves a 3-D Q16.16 point along a stored path at constant speed. Append, set
// position, stop, path-not-found and ignored ticks go from input transfer
// straight to the done state and on to the output register. A moving tick
// reads the target waypoint, squares the three deltas on one shared 33x32
// multiplier, takes the 64-bit square root one result bit per cycle, forms
// the step and compares; a snap then finishes, otherwise each axis needs a
// multiply, a shift-subtract divide and an update. A result-side stall can hold
// a finished item in the done state. The input is stalled while an item is
// in work; a finished result waits in the output register while the next
// item is taken.
module waypoint_follower_step_top #(
	parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         cmd,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic               final_waypoint,
	input  wire logic [15:0]        elapsed,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              agent_status,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic [6:0]              target_index,
	output logic                    path_overflow
);

	localparam int IW = $clog2(MAX_WAYPOINTS + 1);
	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam logic [IW-1:0] MAX_CNT = IW'(MAX_WAYPOINTS);
	localparam logic [IW-1:0] ONE_CNT = IW'(1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SQ   = 10'b0000000010,
		S_ACC  = 10'b0000000100,
		S_SQRT = 10'b0000001000,
		S_STEP = 10'b0000010000,
		S_CMP  = 10'b0000100000,
		S_MUL  = 10'b0001000000,
		S_DIV  = 10'b0010000000,
		S_UPD  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t                state_q;
	logic [30:0]           max_speed_q, arrival_q;
	logic [IW-1:0]         count_q, next_q;
	logic [1:0]            status_q;
	logic                  building_q, ovf_q;
	logic signed [31:0]    pos_q [3];
	logic [1:0]            ax_q;
	logic [5:0]            cnt_q;
	logic                  out_valid_q;
	logic [1:0]            o_status_q;
	logic signed [31:0]    o_pos_q [3];
	logic [6:0]            o_idx_q;
	logic                  o_ovf_q;

	// Datapath registers
	logic [95:0]           mem [MAX_WAYPOINTS];
	logic [95:0]           rd_q;
	logic [15:0]           elapsed_q;
	logic [32:0]           mag_q [3];
	logic [2:0]            neg_q;
	logic [63:0]           prod_q;
	logic                  sat_q;
	logic [63:0]           sum_q, v_q, root_q, bit_q;
	logic [30:0]           step_q;
	logic [32:0]           rem_q, qsh_q;

	logic                  accept, out_free;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [IW-1:0]         base_cnt, new_cnt;
	logic                  full;
	logic                  tick_skip;
	logic [32:0]           mul_a;
	logic [31:0]           mul_b;
	logic [64:0]           mul_p;
	logic signed [32:0]    delta;
	logic [32:0]           mag;
	logic [63:0]           sq;
	logic [64:0]           sum_ext;
	logic [63:0]           sum_new;
	logic [63:0]           sqrt_t;
	logic [31:0]           root_dist;
	logic [30:0]           limit;
	logic [32:0]           div_t;
	logic                  div_ge;
	logic signed [34:0]    upd_sum;
	logic signed [31:0]    upd_pos;
	logic signed [31:0]    wp_ax;
	logic signed [31:0]    in_coord [3];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign in_coord[0] = coord_x;
	assign in_coord[1] = coord_y;
	assign in_coord[2] = coord_z;

	// Append bookkeeping
	assign base_cnt = building_q ? count_q : '0;
	assign full     = (base_cnt >= MAX_CNT);
	assign new_cnt  = full ? base_cnt : base_cnt + ONE_CNT;
	assign wr_en    = accept && (cmd == wpf_pkg::CMD_APPEND) && !full;
	assign wr_addr  = base_cnt[AW-1:0];

	assign tick_skip = (status_q != wpf_pkg::ST_MOVING) || building_q ||
		(elapsed == 16'd0) || (next_q >= count_q);

	// Shared multiplier operand select
	always_comb begin
		mul_a = mag;
		mul_b = mag[31:0];
		unique case (state_q)
			S_STEP:  begin mul_a = 33'(max_speed_q); mul_b = 32'(elapsed_q); end
			S_MUL:   begin mul_a = mag_q[ax_q]; mul_b = {1'b0, step_q}; end
			default: begin mul_a = mag; mul_b = mag[31:0]; end
		endcase
	end
	assign mul_p = 65'(mul_a) * 65'(mul_b);

	// Delta and magnitude of the current axis
	assign wp_ax = rd_q[32*ax_q +: 32];
	assign delta = 33'(wp_ax) - 33'(pos_q[ax_q]);
	assign mag   = delta[32] ? 33'(-delta) : 33'(delta);

	// Saturating square accumulate
	assign sq      = sat_q ? {64{1'b1}} : prod_q;
	assign sum_ext = 65'(sum_q) + 65'(sq);
	assign sum_new = sum_ext[64] ? {64{1'b1}} : sum_ext[63:0];

	assign sqrt_t    = root_q + bit_q;
	assign root_dist = root_q[31:0];
	assign limit     = (arrival_q > step_q) ? arrival_q : step_q;

	assign div_t  = {rem_q[31:0], qsh_q[32]};
	assign div_ge = (div_t >= {1'b0, root_dist});

	// Position update with saturation
	assign upd_sum = neg_q[ax_q] ? 35'(pos_q[ax_q]) - 35'(qsh_q) :
		35'(pos_q[ax_q]) + 35'(qsh_q);
	always_comb begin
		if (upd_sum > 35'sh0_7FFF_FFFF)
			upd_pos = 32'sh7FFF_FFFF;
		else if (upd_sum < -35'sh0_8000_0000)
			upd_pos = -32'sh8000_0000;
		else
			upd_pos = upd_sum[31:0];
	end

	// Waypoint memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {in_coord[2], in_coord[1], in_coord[0]};
		rd_q <= mem[next_q[AW-1:0]];
	end

	// Arithmetic datapath
	always_ff @(posedge clk) begin
		if (accept)
			elapsed_q <= elapsed;
		unique case (state_q)
			S_SQ: begin
				mag_q[ax_q] <= mag;
				neg_q[ax_q] <= delta[32];
				prod_q      <= mul_p[63:0];
				sat_q       <= mag[32];
			end
			S_ACC: begin
				sum_q  <= sum_new;
				v_q    <= sum_new;
				root_q <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end
			S_SQRT: begin
				if (v_q >= sqrt_t) begin
					v_q    <= v_q - sqrt_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_STEP: step_q <= mul_p[46:16];
			S_MUL: begin
				rem_q <= {2'b00, mul_p[63:33]};
				qsh_q <= mul_p[32:0];
			end
			S_DIV: begin
				rem_q <= div_ge ? div_t - {1'b0, root_dist} : div_t;
				qsh_q <= {qsh_q[31:0], div_ge};
			end
			default: ;
		endcase
		if (accept)
			sum_q <= '0;
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_speed_q <= '0;
			arrival_q   <= '0;
			count_q     <= '0;
			next_q      <= '0;
			status_q    <= wpf_pkg::ST_IDLE;
			building_q  <= 1'b0;
			ovf_q       <= 1'b0;
			pos_q[0]    <= '0;
			pos_q[1]    <= '0;
			pos_q[2]    <= '0;
			ax_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wpf_pkg::REG_MAX_SPEED:      max_speed_q <= cfg_data;
					wpf_pkg::REG_ARRIVAL_RADIUS: arrival_q   <= cfg_data;
					default: ;
				endcase
			end
			// Load a finished item, else drop the result once transferred
			out_valid_q <= (state_q == S_DONE && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cmd == wpf_pkg::CMD_TICK && !tick_skip) ? S_SQ : S_DONE;
						ax_q    <= '0;
						unique case (cmd)
							wpf_pkg::CMD_TICK: ;
							wpf_pkg::CMD_APPEND: begin
								count_q <= new_cnt;
								ovf_q   <= (building_q && ovf_q) || full;
								if (final_waypoint) begin
									building_q <= 1'b0;
									next_q     <= (new_cnt > ONE_CNT) ? ONE_CNT : '0;
									status_q   <= wpf_pkg::ST_MOVING;
								end else begin
									building_q <= 1'b1;
									if (!building_q)
										next_q <= '0;
								end
							end
							wpf_pkg::CMD_SET_POS: begin
								pos_q[0] <= coord_x;
								pos_q[1] <= coord_y;
								pos_q[2] <= coord_z;
							end
							wpf_pkg::CMD_STOP, wpf_pkg::CMD_NOTFOUND: begin
								count_q    <= '0;
								next_q     <= '0;
								ovf_q      <= 1'b0;
								building_q <= 1'b0;
								status_q   <= (cmd == wpf_pkg::CMD_STOP) ?
									wpf_pkg::ST_IDLE : wpf_pkg::ST_NOTFOUND;
							end
							default: ;
						endcase
					end
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SQ;
					end
				end
				S_SQRT: begin
					if (bit_q == 64'd1)
						state_q <= S_STEP;
				end
				S_STEP: state_q <= S_CMP;
				S_CMP: begin
					if ({1'b0, root_dist} <= {2'b00, limit}) begin
						pos_q[0] <= rd_q[31:0];
						pos_q[1] <= rd_q[63:32];
						pos_q[2] <= rd_q[95:64];
						next_q   <= next_q + ONE_CNT;
						if (next_q + ONE_CNT >= count_q)
							status_q <= wpf_pkg::ST_ARRIVED;
						state_q <= S_DONE;
					end else begin
						ax_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32)
						state_q <= S_UPD;
				end
				S_UPD: begin
					pos_q[ax_q] <= upd_pos;
					if (ax_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_status_q <= status_q;
			o_pos_q[0] <= pos_q[0];
			o_pos_q[1] <= pos_q[1];
			o_pos_q[2] <= pos_q[2];
			o_idx_q    <= 7'(next_q);
			o_ovf_q    <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign agent_status  = o_status_q;
	assign pos_x         = o_pos_q[0];
	assign pos_y         = o_pos_q[1];
	assign pos_z         = o_pos_q[2];
	assign target_index  = o_idx_q;
	assign path_overflow = o_ovf_q;

	// Checks
	a_next_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= count_q) else $error("target index beyond path length");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT) else $error("waypoint count beyond store depth");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q)
		else $error("finished item not presented");
	a_root_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (root_q[63:32] == 32'd0))
		else $error("square root wider than 32 bits");

endmodule
`default_nettype wire

FILE: tb/waypoint_follower_step_top_tb.sv
// Testbench for the waypoint follower: random-idle valid/stall traffic, an in-bench
// predictor of path, position and status, and an in-order result check.
// Depends on wpf_pkg and waypoint_follower_step_top.
`default_nettype none
module waypoint_follower_step_top_tb;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [6:0]         tgt;
		logic               ovf;
	} follow_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic final_waypoint = 1'b0;
	logic [15:0] elapsed = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] agent_status;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [6:0] target_index;
	logic path_overflow;

	waypoint_follower_step_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.final_waypoint(final_waypoint), .elapsed(elapsed), .out_valid(out_valid),
		.out_stall(out_stall), .agent_status(agent_status), .pos_x(pos_x),
		.pos_y(pos_y), .pos_z(pos_z), .target_index(target_index),
		.path_overflow(path_overflow)
	);

	// Predictor state
	longint unsigned speed_q, radius_q;
	longint path_pts [wpf_pkg::MAX_WAYPOINTS][3];
	int unsigned path_len, aim_idx;
	longint cur_pos [3];
	wpf_pkg::status_t follow_status;
	bit building, dropped;

	follow_state_t expected_states [$];
	int errors = 0;
	bit idle_on = 1'b1;
	int n_results = 0;

	initial forever #6 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	function automatic void clear_route();
		path_len = 0;
		aim_idx = 0;
		dropped = 1'b0;
	endfunction

	// Advance the point toward the target for one tick
	function automatic void advance_point(longint unsigned dt);
		longint d [3];
		longint unsigned mag [3];
		longint unsigned sum, sq, root_dist, stp, lim, q;
		sum = 0;
		if (follow_status != wpf_pkg::ST_MOVING || building || dt == 0 ||
				aim_idx >= path_len || aim_idx >= wpf_pkg::MAX_WAYPOINTS)
			return;
		for (int i = 0; i < 3; i++) begin
			d[i] = path_pts[aim_idx][i] - cur_pos[i];
			mag[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
			sq = mag[i] > 64'hFFFFFFFF ? '1 : mag[i] * mag[i];
			sum = ('1 - sum < sq) ? '1 : sum + sq;
		end
		root_dist = int_sqrt(sum);
		stp = (speed_q * dt) >> 16;
		lim = radius_q > stp ? radius_q : stp;
		if (root_dist <= lim) begin
			for (int i = 0; i < 3; i++) cur_pos[i] = path_pts[aim_idx][i];
			aim_idx++;
			if (aim_idx >= path_len) follow_status = wpf_pkg::ST_ARRIVED;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * stp) / root_dist;
			cur_pos[i] = sat32(cur_pos[i] + (d[i] < 0 ? -longint'(q) : longint'(q)));
		end
	endfunction

	function automatic follow_state_t apply_command(logic [2:0] c, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic fin, logic [15:0] dt);
		follow_state_t r;
		case (c)
			wpf_pkg::CMD_TICK: begin
				advance_point(dt);
			end
			wpf_pkg::CMD_APPEND: begin
				if (!building) begin
					clear_route();
					building = 1'b1;
				end
				if (path_len < wpf_pkg::MAX_WAYPOINTS) begin
					path_pts[path_len][0] = x;
					path_pts[path_len][1] = y;
					path_pts[path_len][2] = z;
					path_len++;
				end else begin
					dropped = 1'b1;
				end
				if (fin) begin
					building = 1'b0;
					aim_idx = path_len > 1 ? 1 : 0;
					follow_status = wpf_pkg::ST_MOVING;
				end
			end
			wpf_pkg::CMD_SET_POS: begin
				cur_pos[0] = x;
				cur_pos[1] = y;
				cur_pos[2] = z;
			end
			wpf_pkg::CMD_STOP, wpf_pkg::CMD_NOTFOUND: begin
				clear_route();
				building = 1'b0;
				follow_status = (c == wpf_pkg::CMD_STOP) ? wpf_pkg::ST_IDLE :
					wpf_pkg::ST_NOTFOUND;
			end
			default: ;
		endcase
		r.status = follow_status;
		r.px = cur_pos[0][31:0];
		r.py = cur_pos[1][31:0];
		r.pz = cur_pos[2][31:0];
		r.tgt = aim_idx[6:0];
		r.ovf = dropped;
		return r;
	endfunction

	// Send one item, predict it on transfer; valid stays up for a following item
	task automatic send_item(logic [2:0] c, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic fin, logic [15:0] dt);
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		final_waypoint <= fin;
		elapsed <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_states.push_back(apply_command(c, x, y, z, fin, dt));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_states.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(wpf_pkg::reg_index_t idx, logic [30:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == wpf_pkg::REG_MAX_SPEED) speed_q = v;
		else radius_q = v;
	endtask

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
	endfunction

	function automatic logic signed [31:0] any_coord();
		return $urandom_range(3) == 0 ? near_coord() : $signed($urandom());
	endfunction

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		follow_state_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {agent_status, pos_x, pos_y, pos_z, target_index, path_overflow};
			if (expected_states.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_states.pop_front();
				n_results++;
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.px !== want.px)
					$display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
				if (got.py !== want.py)
					$display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
				if (got.pz !== want.pz)
					$display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz);
				if (got.tgt !== want.tgt)
					$display("%0t: target_index exp %0d got %0d", $time, want.tgt, got.tgt);
				if (got.ovf !== want.ovf)
					$display("%0t: path_overflow exp %0d got %0d", $time, want.ovf, got.ovf);
				if (got !== want) errors++;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 36);
	end

	task automatic test_directed();
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'hFFFF);
		send_item(wpf_pkg::CMD_SET_POS, 32'sh7FFFFFFF, 32'sh80000000, 0, 1'b1, 0);
		send_item(3'd5, '1, '1, '1, 1'b1, '1);
		send_item(3'd6, 0, 0, 0, 1'b0, 0);
		send_item(3'd7, 0, 0, 0, 1'b1, 1);
		// Single waypoint path, far away at the extremes
		send_item(wpf_pkg::CMD_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1,
			16'hFFFF);
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 0);
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'hFFFF);
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'h0001);
		send_item(wpf_pkg::CMD_NOTFOUND, 1, 2, 3, 1'b1, 1);
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'hFFFF);
		send_item(wpf_pkg::CMD_SET_POS, 0, 0, 0, 1'b0, 0);
		send_item(wpf_pkg::CMD_APPEND, 32'sh0001_0000, 0, 0, 1'b0, 0);
		send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'h8000);
		send_item(wpf_pkg::CMD_APPEND, 32'sh0010_0000, 32'sh0008_0000, 0, 1'b0, 0);
		send_item(wpf_pkg::CMD_APPEND, 0, 0, 32'sh0004_0000, 1'b1, 0);
		repeat (4) send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'h4000);
		send_item(wpf_pkg::CMD_STOP, 0, 0, 0, 1'b0, 0);
	endtask

	task automatic test_store_full();
		for (int i = 0; i < wpf_pkg::MAX_WAYPOINTS + 2; i++)
			send_item(wpf_pkg::CMD_APPEND, near_coord(), near_coord(), near_coord(),
				i == wpf_pkg::MAX_WAYPOINTS + 1, 0);
		repeat (80) send_item(wpf_pkg::CMD_TICK, 0, 0, 0, 1'b0, 16'hFFFF);
	endtask

	task automatic test_random_paths(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(3'($urandom_range(7)), any_coord(), any_coord(), any_coord(),
					1'($urandom_range(1)), 16'($urandom()));
				sent++;
				continue;
			end
			if ($urandom_range(2) == 0) begin
				send_item(wpf_pkg::CMD_SET_POS, near_coord(), near_coord(), near_coord(),
					1'b0, 16'd0);
				sent++;
			end
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				send_item(wpf_pkg::CMD_APPEND, any_coord(), any_coord(), any_coord(),
					i == len - 1, 16'($urandom()));
				sent++;
			end
			for (int i = $urandom_range(3, 14); i > 0; i--) begin
				send_item(wpf_pkg::CMD_TICK, $urandom(), $urandom(), $urandom(),
					1'($urandom_range(1)),
					$urandom_range(3) == 0 ? 16'd0 : 16'($urandom()));
				sent++;
			end
			if ($urandom_range(4) == 0) begin
				send_item($urandom_range(1) ? wpf_pkg::CMD_STOP : wpf_pkg::CMD_NOTFOUND,
					$urandom(), 0, 0, 1'($urandom_range(1)), 16'd0);
				sent++;
			end
		end
	endtask

	initial begin
		speed_q = 0;
		radius_q = 0;
		path_len = 0;
		aim_idx = 0;
		cur_pos = '{0, 0, 0};
		follow_status = wpf_pkg::ST_IDLE;
		building = 1'b0;
		dropped = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_reg(wpf_pkg::REG_MAX_SPEED, 31'h7FFF_FFFF);
		write_reg(wpf_pkg::REG_ARRIVAL_RADIUS, 31'h7FFF_FFFF);
		test_directed();
		write_reg(wpf_pkg::REG_MAX_SPEED, 31'h0010_0000);
		write_reg(wpf_pkg::REG_ARRIVAL_RADIUS, 31'h0000_8000);
		test_directed();
		test_store_full();
		test_random_paths(350);
		// Long stretch with no idling on either side
		idle_on = 1'b0;
		write_reg(wpf_pkg::REG_MAX_SPEED, 31'($urandom()));
		write_reg(wpf_pkg::REG_ARRIVAL_RADIUS, 31'($urandom_range(32'h0008_0000)));
		test_random_paths(200);
		idle_on = 1'b1;
		write_reg(wpf_pkg::REG_MAX_SPEED, 31'h0040_0000);
		write_reg(wpf_pkg::REG_ARRIVAL_RADIUS, 31'd0);
		test_random_paths(200);
		drain_results();

		if (errors == 0)
			$display("** waypoint_follower_step_top: PASSED **");
		else
			$display("** waypoint_follower_step_top: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** waypoint_follower_step_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
